// ----- sv/dictionary_word_masker_macros.svh -----
// assertion macros for the dictionary word masker
// no dependencies; included by dictionary_word_masker.sv, the rtl file that carries checks
`ifndef DICTIONARY_WORD_MASKER_MACROS_SVH
`define DICTIONARY_WORD_MASKER_MACROS_SVH

`ifndef ASSERT_OFF
// property that must hold at every edge outside reset
`define DWM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// implication checked at every edge outside reset
`define DWM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define DWM_ASSERT(lbl, clk, rstn, prop, msg)
`define DWM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- sv/dwm_pkg.sv -----
// shared types, codes and character functions of the dictionary word masker
// no dependencies
`default_nettype none

package dwm_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_DICT_CHAR = 3'd1,
        CMD_DICT_END  = 3'd2,
        CMD_TEXT_CHAR = 3'd3,
        CMD_LINE_END  = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FEED1,
        S_FEED2,
        S_FLUSH,
        S_LEN_RD,
        S_LEN_CHK,
        S_CHR_RD,
        S_CHR_CHK,
        S_STORE_RD,
        S_STORE_WR,
        S_STATUS,
        S_EMIT_RD,
        S_EMIT_WR,
        S_SINGLE
    } state_t;

    // dictionary memory strobes
    typedef struct packed {
        logic len_rd;
        logic len_we;
        logic chr_rd;
        logic chr_we;
    } dict_ctl_t;

    localparam logic       KIND_TEXT   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;
    localparam logic [1:0] STAT_STORED = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [15:0] CHAR_STAR  = 16'h002A;
    localparam logic [15:0] CHAR_F     = 16'h0066;

    function automatic logic is_delim(input logic [15:0] c);
        logic r;
        case (c)
            16'h0020, 16'h003B, 16'h002C, 16'h002E, 16'h0021, 16'h003F,
            16'h003A, 16'h003D, 16'h005C, 16'h002F, 16'h003E, 16'h003C,
            16'h0060, 16'h007E, 16'h0028, 16'h0029, 16'h0026, 16'h005E,
            16'h0025, 16'h0023, 16'h000A, 16'h0009: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_drop(input logic [15:0] c);
        logic r;
        case (c)
            16'h002D, 16'h005F, 16'h002A, 16'h0027, 16'h0022: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_p(input logic [15:0] c);
        return (c == 16'h0070) || (c == 16'h0050);
    endfunction

    function automatic logic is_h(input logic [15:0] c);
        return (c == 16'h0068) || (c == 16'h0048);
    endfunction

    // leetspeak digits and symbols to letters
    function automatic logic [15:0] norm_map(input logic [15:0] c);
        logic [15:0] r;
        case (c)
            16'h0031: r = 16'h006C;
            16'h0033: r = 16'h0065;
            16'h0034: r = 16'h0061;
            16'h0035: r = 16'h0073;
            16'h0036: r = 16'h0062;
            16'h0037: r = 16'h0074;
            16'h0030: r = 16'h006F;
            16'h0040: r = 16'h0061;
            16'h0024: r = 16'h0073;
            16'h002B: r = 16'h0074;
            default:  r = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/dictionary_word_masker.sv -----
// dictionary word masker: load a normalized word table, mask matching text tokens
// depends on dwm_pkg, dwm_buf, dwm_dict and the assertion macro header
//
// Usage. Input transfers carry a command in s_tuser and a character in s_tdata.
// Dictionary characters are decoded with the key from cfg_wdata and
// normalized into a load buffer; end of word stores it and answers with one
// status transfer. Text characters are buffered per token; at a delimiter or
// end of line the token leaves as asterisks if its normalized form is in the
// table, else unchanged, followed by the delimiter. m_tlast marks the final
// transfer caused by one input transfer.
// Timing. One item is taken at a time: s_tready is high only between items.
// A plain character passes the two feed states. A token end or end of
// dictionary word reads and checks the length of each table entry and each
// character of an entry of equal length, then reads and writes each emitted
// token character and sends the delimiter or status; storing a word reads and
// writes each character. The search loop over the single-port dictionary memory sets the rate.
// Reset empties the table and all buffers at once; no clearing pass.
// When m_tready is low the result waits in the output register and the
// sequencer stalls on the next result; s_tready stays low until done.
`default_nettype none
`include "dictionary_word_masker_macros.svh"

module dictionary_word_masker
    import dwm_pkg::*;
#(
    parameter int MAX_WORD    = 32,
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,   // xor_key
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // ch
    input  wire logic [2:0]  s_tuser,     // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // out_char [15:0], status [17:16], zero fill
    output logic             m_tuser,     // kind
    output logic             m_tlast
);

    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int KW = $clog2(MAX_WORD);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    state_t state_reg, state_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [15:0]   ch_reg, ch_next;
    logic [15:0]   key_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] lraw_reg, lraw_next, llen_reg, llen_next;
    logic          lpv_reg, lpv_next;
    logic [15:0]   lpc_reg, lpc_next;
    logic [LW-1:0] rlen_reg, rlen_next, nlen_reg, nlen_next;
    logic          tpv_reg, tpv_next;
    logic [15:0]   tpc_reg, tpc_next;
    logic          pass_reg, pass_next;
    logic [CW-1:0] e_reg, e_next;
    logic [KW-1:0] k_reg, k_next;
    logic          hit_reg, hit_next, ovf_reg, ovf_next, heat_reg, heat_next;
    logic [1:0]    stat_reg, stat_next;
    logic          out_v_reg, out_v_next, out_kind_reg, out_kind_next;
    logic          out_last_reg, out_last_next;
    logic [15:0]   out_char_reg, out_char_next;
    logic [1:0]    out_stat_reg, out_stat_next;

    logic          s_fire, out_free, dict_side, search_more, k_last, chr_eq, len_eq;
    logic [LW-1:0] word_len;
    logic [15:0]   word_rd, raw_rd, norm_rd, load_rd;
    logic          pend_v;

    // memory strobes
    dict_ctl_t     dctl;
    logic [EW-1:0]    len_addr;
    logic [LW-1:0]    len_wdata, len_rdata;
    logic [EW+KW-1:0] chr_addr;
    logic [15:0]      chr_rdata;
    logic          raw_we, norm_we, load_we, raw_rd_en, norm_rd_en, load_rd_en;
    logic [15:0]   norm_wdata, load_wdata;

    assign s_tready    = (state_reg == S_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign out_free    = !out_v_reg || m_tready;
    assign dict_side   = (cmd_reg == CMD_DICT_END) || (cmd_reg == CMD_DICT_CHAR);
    assign word_len    = dict_side ? llen_reg : nlen_reg;
    assign word_rd     = dict_side ? load_rd : norm_rd;
    assign search_more = (e_reg < cnt_reg);
    assign pend_v      = dict_side ? lpv_reg : tpv_reg;
    assign chr_eq      = (chr_rdata == word_rd);
    assign len_eq      = (len_rdata == word_len);
    assign len_wdata   = llen_reg;
    assign chr_addr    = (state_reg == S_STORE_WR) ? {cnt_reg[EW-1:0], k_reg}
                                                   : {e_reg[EW-1:0], k_reg};
    assign len_addr    = ((state_reg == S_LEN_RD) && search_more) ? e_reg[EW-1:0]
                                                                  : cnt_reg[EW-1:0];

    // end of the current character loop
    always_comb begin
        case (state_reg)
            S_EMIT_WR: k_last = ((LW'(k_reg) + LW'(1)) == rlen_reg);
            S_STORE_WR: k_last = ((LW'(k_reg) + LW'(1)) == llen_reg);
            default:   k_last = ((LW'(k_reg) + LW'(1)) == word_len);
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        CMD_DICT_CHAR: begin
                            if (lraw_reg < LW'(MAX_WORD)) begin
                                state_next = S_FEED1;
                            end
                        end
                        CMD_DICT_END: state_next = S_FLUSH;
                        CMD_LINE_END: state_next = S_FLUSH;
                        CMD_TEXT_CHAR: begin
                            if (is_delim(s_tdata)) begin
                                state_next = S_FLUSH;
                            end else if (pass_reg) begin
                                state_next = S_SINGLE;
                            end else if (rlen_reg < LW'(MAX_WORD)) begin
                                state_next = S_FEED1;
                            end else begin
                                state_next = S_EMIT_RD;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_FEED1: state_next = S_FEED2;
            S_FEED2: state_next = S_IDLE;
            S_FLUSH: begin
                if (cmd_reg == CMD_DICT_END) begin
                    state_next = (lraw_reg == '0) ? S_STATUS : S_LEN_RD;
                end else if (rlen_reg != '0) begin
                    state_next = S_LEN_RD;
                end else begin
                    state_next = (cmd_reg == CMD_TEXT_CHAR) ? S_SINGLE : S_IDLE;
                end
            end
            S_LEN_RD: begin
                if (search_more) begin
                    state_next = S_LEN_CHK;
                end else if (!dict_side) begin
                    state_next = S_EMIT_RD;
                end else if ((cnt_reg >= CW'(TABLE_DEPTH)) || (llen_reg == '0)) begin
                    state_next = S_STATUS;
                end else begin
                    state_next = S_STORE_RD;
                end
            end
            S_LEN_CHK: begin
                if (len_eq && (word_len == '0)) begin
                    state_next = dict_side ? S_STATUS : S_EMIT_RD;
                end else if (len_eq) begin
                    state_next = S_CHR_RD;
                end else begin
                    state_next = S_LEN_RD;
                end
            end
            S_CHR_RD: state_next = S_CHR_CHK;
            S_CHR_CHK: begin
                if (chr_eq && k_last) begin
                    state_next = dict_side ? S_STATUS : S_EMIT_RD;
                end else if (chr_eq) begin
                    state_next = S_CHR_RD;
                end else begin
                    state_next = S_LEN_RD;
                end
            end
            S_STORE_RD: state_next = S_STORE_WR;
            S_STORE_WR: state_next = k_last ? S_STATUS : S_STORE_RD;
            S_STATUS: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_RD: state_next = S_EMIT_WR;
            S_EMIT_WR: begin
                if (out_free && k_last) begin
                    state_next = (cmd_reg == CMD_TEXT_CHAR) ? S_SINGLE : S_IDLE;
                end else if (out_free) begin
                    state_next = S_EMIT_RD;
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        cmd_next = cmd_reg;   ch_next = ch_reg;     cnt_next = cnt_reg;
        lraw_next = lraw_reg; llen_next = llen_reg; lpv_next = lpv_reg;
        lpc_next = lpc_reg;   rlen_next = rlen_reg; nlen_next = nlen_reg;
        tpv_next = tpv_reg;   tpc_next = tpc_reg;   pass_next = pass_reg;
        e_next = e_reg;       k_next = k_reg;       hit_next = hit_reg;
        ovf_next = ovf_reg;   heat_next = heat_reg; stat_next = stat_reg;
        out_v_next = out_v_reg && !m_tready;
        out_kind_next = out_kind_reg; out_char_next = out_char_reg;
        out_stat_next = out_stat_reg; out_last_next = out_last_reg;
        dctl = '0;
        raw_we = 1'b0; norm_we = 1'b0; load_we = 1'b0;
        raw_rd_en = 1'b0; norm_rd_en = 1'b0; load_rd_en = 1'b0;
        norm_wdata = ch_reg; load_wdata = ch_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    cmd_next = s_tuser;
                    ch_next  = (s_tuser == CMD_DICT_CHAR) ? (s_tdata ^ key_reg) : s_tdata;
                    hit_next = 1'b0;
                    ovf_next = 1'b0;
                    k_next   = '0;
                    case (s_tuser)
                        CMD_CLEAR: begin
                            cnt_next  = '0;
                            lraw_next = '0;
                            llen_next = '0;
                            lpv_next  = 1'b0;
                        end
                        CMD_DICT_CHAR: begin
                            if (lraw_reg < LW'(MAX_WORD)) begin
                                lraw_next = lraw_reg + LW'(1);
                            end
                        end
                        CMD_TEXT_CHAR: begin
                            if (!is_delim(s_tdata) && !pass_reg &&
                                (rlen_reg >= LW'(MAX_WORD))) begin
                                ovf_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // raw store and release of a pending p
            S_FEED1: begin
                if (!dict_side) begin
                    raw_we    = 1'b1;
                    rlen_next = rlen_reg + LW'(1);
                end
                heat_next = pend_v && is_h(ch_reg);
                if (pend_v) begin
                    if (dict_side) begin
                        load_wdata = is_h(ch_reg) ? CHAR_F : lpc_reg;
                        load_we    = (llen_reg < LW'(MAX_WORD));
                        llen_next  = load_we ? llen_reg + LW'(1) : llen_reg;
                        lpv_next   = 1'b0;
                    end else begin
                        norm_wdata = is_h(ch_reg) ? CHAR_F : tpc_reg;
                        norm_we    = (nlen_reg < LW'(MAX_WORD));
                        nlen_next  = norm_we ? nlen_reg + LW'(1) : nlen_reg;
                        tpv_next   = 1'b0;
                    end
                end
            end
            // normalize the character itself
            S_FEED2: begin
                if (!heat_reg) begin
                    if (is_p(ch_reg)) begin
                        if (dict_side) begin
                            lpv_next = 1'b1;
                            lpc_next = ch_reg;
                        end else begin
                            tpv_next = 1'b1;
                            tpc_next = ch_reg;
                        end
                    end else if (!is_drop(ch_reg)) begin
                        if (dict_side) begin
                            load_wdata = norm_map(ch_reg);
                            load_we    = (llen_reg < LW'(MAX_WORD));
                            llen_next  = load_we ? llen_reg + LW'(1) : llen_reg;
                        end else begin
                            norm_wdata = norm_map(ch_reg);
                            norm_we    = (nlen_reg < LW'(MAX_WORD));
                            nlen_next  = norm_we ? nlen_reg + LW'(1) : nlen_reg;
                        end
                    end
                end
            end
            // flush a pending p before the search
            S_FLUSH: begin
                e_next = '0;
                k_next = '0;
                if (dict_side) begin
                    stat_next = STAT_EMPTY;
                    if (lpv_reg) begin
                        load_wdata = lpc_reg;
                        load_we    = (llen_reg < LW'(MAX_WORD));
                        llen_next  = load_we ? llen_reg + LW'(1) : llen_reg;
                    end
                    lpv_next = 1'b0;
                end else begin
                    if (tpv_reg) begin
                        norm_wdata = tpc_reg;
                        norm_we    = (nlen_reg < LW'(MAX_WORD));
                        nlen_next  = norm_we ? nlen_reg + LW'(1) : nlen_reg;
                    end
                    tpv_next = 1'b0;
                    if (rlen_reg == '0) begin
                        pass_next = 1'b0;
                    end
                end
            end
            S_LEN_RD: begin
                k_next = '0;
                if (search_more) begin
                    dctl.len_rd = 1'b1;
                end else if (dict_side) begin
                    if (cnt_reg >= CW'(TABLE_DEPTH)) begin
                        stat_next = STAT_FULL;
                    end else begin
                        stat_next = STAT_STORED;
                        if (llen_reg == '0) begin
                            dctl.len_we = 1'b1;
                            cnt_next    = cnt_reg + CW'(1);
                        end
                    end
                end
            end
            S_LEN_CHK: begin
                if (len_eq && (word_len == '0)) begin
                    hit_next  = 1'b1;
                    stat_next = STAT_STORED;
                end else if (!len_eq) begin
                    e_next = e_reg + CW'(1);
                end
            end
            S_CHR_RD: begin
                dctl.chr_rd = 1'b1;
                norm_rd_en  = !dict_side;
                load_rd_en  = dict_side;
            end
            S_CHR_CHK: begin
                if (chr_eq && k_last) begin
                    hit_next  = 1'b1;
                    stat_next = STAT_STORED;
                    k_next    = '0;
                end else if (chr_eq) begin
                    k_next = k_reg + KW'(1);
                end else begin
                    e_next = e_reg + CW'(1);
                    k_next = '0;
                end
            end
            S_STORE_RD: load_rd_en = 1'b1;
            S_STORE_WR: begin
                dctl.chr_we = 1'b1;
                if (k_last) begin
                    dctl.len_we = 1'b1;
                    cnt_next    = cnt_reg + CW'(1);
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    out_v_next    = 1'b1;
                    out_kind_next = KIND_STATUS;
                    out_char_next = '0;
                    out_stat_next = stat_reg;
                    out_last_next = 1'b1;
                    lraw_next     = '0;
                    llen_next     = '0;
                    lpv_next      = 1'b0;
                end
            end
            S_EMIT_RD: raw_rd_en = 1'b1;
            S_EMIT_WR: begin
                if (out_free) begin
                    out_v_next    = 1'b1;
                    out_kind_next = KIND_TEXT;
                    out_char_next = hit_reg ? CHAR_STAR : raw_rd;
                    out_stat_next = STAT_STORED;
                    out_last_next = k_last && (cmd_reg == CMD_LINE_END);
                    if (k_last) begin
                        rlen_next = '0;
                        nlen_next = '0;
                        tpv_next  = 1'b0;
                        pass_next = ovf_reg;
                    end else begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    out_v_next    = 1'b1;
                    out_kind_next = KIND_TEXT;
                    out_char_next = ch_reg;
                    out_stat_next = STAT_STORED;
                    out_last_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            key_reg   <= '0;
            cnt_reg   <= '0;
            lraw_reg  <= '0;
            llen_reg  <= '0;
            lpv_reg   <= 1'b0;
            rlen_reg  <= '0;
            nlen_reg  <= '0;
            tpv_reg   <= 1'b0;
            pass_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                key_reg <= cfg_wdata;
            end
            cnt_reg   <= cnt_next;
            lraw_reg  <= lraw_next;
            llen_reg  <= llen_next;
            lpv_reg   <= lpv_next;
            rlen_reg  <= rlen_next;
            nlen_reg  <= nlen_next;
            tpv_reg   <= tpv_next;
            pass_reg  <= pass_next;
            out_v_reg <= out_v_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        ch_reg       <= ch_next;
        lpc_reg      <= lpc_next;
        tpc_reg      <= tpc_next;
        e_reg        <= e_next;
        k_reg        <= k_next;
        hit_reg      <= hit_next;
        ovf_reg      <= ovf_next;
        heat_reg     <= heat_next;
        stat_reg     <= stat_next;
        out_kind_reg <= out_kind_next;
        out_char_reg <= out_char_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    // token and word buffers
    dwm_buf #(.DEPTH(MAX_WORD), .AW(KW)) u_raw (
        .aclk    (aclk),
        .wr_en   (raw_we),
        .wr_addr (rlen_reg[KW-1:0]),
        .wr_data (ch_reg),
        .rd_en   (raw_rd_en),
        .rd_addr (k_reg),
        .rd_data (raw_rd)
    );

    dwm_buf #(.DEPTH(MAX_WORD), .AW(KW)) u_norm (
        .aclk    (aclk),
        .wr_en   (norm_we),
        .wr_addr (nlen_reg[KW-1:0]),
        .wr_data (norm_wdata),
        .rd_en   (norm_rd_en),
        .rd_addr (k_reg),
        .rd_data (norm_rd)
    );

    dwm_buf #(.DEPTH(MAX_WORD), .AW(KW)) u_load (
        .aclk    (aclk),
        .wr_en   (load_we),
        .wr_addr (llen_reg[KW-1:0]),
        .wr_data (load_wdata),
        .rd_en   (load_rd_en),
        .rd_addr (k_reg),
        .rd_data (load_rd)
    );

    // dictionary table
    dwm_dict #(.EW(EW), .KW(KW), .LW(LW)) u_dict (
        .aclk      (aclk),
        .ctl       (dctl),
        .len_addr  (len_addr),
        .len_wdata (len_wdata),
        .len_rdata (len_rdata),
        .chr_addr  (chr_addr),
        .chr_wdata (load_rd),
        .chr_rdata (chr_rdata)
    );

    // result channel
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'b0, out_stat_reg, out_char_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // consistency checks
    `DWM_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CW'(TABLE_DEPTH), "table count overflow")
    `DWM_ASSERT(a_norm_le_raw, aclk, aresetn, nlen_reg <= rlen_reg, "normalized token too long")
    `DWM_ASSERT(a_load_le_raw, aclk, aresetn, llen_reg <= lraw_reg, "normalized word too long")
    `DWM_ASSERT_IMPL(a_pass_empty, aclk, aresetn, pass_reg, rlen_reg == '0, "buffer in passthrough")

endmodule

`default_nettype wire

// ----- sv/dwm_buf.sv -----
// word buffer: one write port, one registered read port
// uses no package items
`default_nettype none

module dwm_buf #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [15:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/dwm_dict.sv -----
// dictionary store: character memory addressed by entry and position,
// plus a length memory; depends on dwm_pkg for the strobe struct
`default_nettype none

module dwm_dict
    import dwm_pkg::*;
#(
    parameter int EW = 6,
    parameter int KW = 5,
    parameter int LW = 6
) (
    input  wire logic             aclk,
    input  wire dict_ctl_t        ctl,
    input  wire logic [EW-1:0]    len_addr,
    input  wire logic [LW-1:0]    len_wdata,
    output logic      [LW-1:0]    len_rdata,
    input  wire logic [EW+KW-1:0] chr_addr,
    input  wire logic [15:0]      chr_wdata,
    output logic      [15:0]      chr_rdata
);

    logic [15:0]   chr_mem [2**(EW+KW)];
    logic [LW-1:0] len_mem [2**EW];

    // character memory
    always_ff @(posedge aclk) begin
        if (ctl.chr_we) begin
            chr_mem[chr_addr] <= chr_wdata;
        end
        if (ctl.chr_rd) begin
            chr_rdata <= chr_mem[chr_addr];
        end
    end

    // length memory
    always_ff @(posedge aclk) begin
        if (ctl.len_we) begin
            len_mem[len_addr] <= len_wdata;
        end
        if (ctl.len_rd) begin
            len_rdata <= len_mem[len_addr];
        end
    end

endmodule

`default_nettype wire

// ----- verif/dwm_checker.sv -----
// result checker of the dictionary word masker: predicts and compares output transfers
// depends on dwm_pkg; watches the input, output and key write ports
`timescale 1ns / 1ps

module dwm_checker
    import dwm_pkg::*;
#(
    parameter int MAX_WORD    = 32,
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending_count,
    output int               result_count
);

    typedef struct packed {
        logic        kind;
        logic [15:0] out_char;
        logic [1:0]  status;
        logic        last;
    } masker_out_t;

    masker_out_t expected_out[$];

    // model state
    logic [15:0] key;
    logic [15:0] words[TABLE_DEPTH][MAX_WORD];
    int          word_len[TABLE_DEPTH];
    int          word_count;
    int          load_raw, load_len;
    logic [16:0] load_p;
    logic [15:0] load_buf[MAX_WORD];
    logic [15:0] tok_raw[MAX_WORD];
    int          tok_raw_len;
    logic [15:0] tok_norm[MAX_WORD];
    int          tok_norm_len;
    logic [16:0] tok_p;
    logic        passing;
    int          step_n;

    function automatic logic [15:0] leet(input logic [15:0] c);
        case (c)
            16'h0031: return 16'h006C;
            16'h0033: return 16'h0065;
            16'h0034: return 16'h0061;
            16'h0035: return 16'h0073;
            16'h0036: return 16'h0062;
            16'h0037: return 16'h0074;
            16'h0030: return 16'h006F;
            16'h0040: return 16'h0061;
            16'h0024: return 16'h0073;
            16'h002B: return 16'h0074;
            default:  return c;
        endcase
    endfunction

    function automatic bit dropped(input logic [15:0] c);
        return c == 16'h002D || c == 16'h005F || c == 16'h002A || c == 16'h0027
            || c == 16'h0022;
    endfunction

    function automatic bit delimiter(input logic [15:0] c);
        logic [15:0] d[22] = '{16'h20, 16'h3B, 16'h2C, 16'h2E, 16'h21, 16'h3F, 16'h3A,
            16'h3D, 16'h5C, 16'h2F, 16'h3E, 16'h3C, 16'h60, 16'h7E, 16'h28, 16'h29,
            16'h26, 16'h5E, 16'h25, 16'h23, 16'h0A, 16'h09};
        foreach (d[i]) if (d[i] == c) return 1;
        return 0;
    endfunction

    task automatic emit(input logic kind, input logic [15:0] c, input logic [1:0] st);
        masker_out_t r;
        r.kind = kind;
        r.out_char = c;
        r.status = st;
        r.last = 1'b0;
        expected_out.push_back(r);
        step_n++;
    endtask

    task automatic append(ref logic [15:0] buf_q[MAX_WORD], ref int len, input logic [15:0] c);
        if (len < MAX_WORD) begin
            buf_q[len] = c;
            len++;
        end
    endtask

    // ph folding, leet mapping, dropped punctuation
    task automatic normalize(ref logic [16:0] pend, ref logic [15:0] buf_q[MAX_WORD],
                             ref int len, input logic [15:0] c);
        if (pend[16]) begin
            pend[16] = 1'b0;
            if (c == 16'h68 || c == 16'h48) begin
                append(buf_q, len, 16'h66);
                return;
            end
            append(buf_q, len, pend[15:0]);
        end
        if (c == 16'h70 || c == 16'h50) begin
            pend = {1'b1, c};
        end else if (!dropped(c)) begin
            append(buf_q, len, leet(c));
        end
    endtask

    task automatic flush(ref logic [16:0] pend, ref logic [15:0] buf_q[MAX_WORD], ref int len);
        if (pend[16]) append(buf_q, len, pend[15:0]);
        pend = '0;
    endtask

    function automatic bit known_word(input logic [15:0] w[MAX_WORD], input int len);
        bit same;
        for (int e = 0; e < word_count; e++) begin
            if (word_len[e] != len) continue;
            same = 1;
            for (int k = 0; k < len; k++) if (words[e][k] != w[k]) same = 0;
            if (same) return 1;
        end
        return 0;
    endfunction

    task automatic close_token();
        bit hit;
        flush(tok_p, tok_norm, tok_norm_len);
        if (tok_raw_len > 0) begin
            hit = known_word(tok_norm, tok_norm_len);
            for (int i = 0; i < tok_raw_len; i++)
                emit(KIND_TEXT, hit ? CHAR_STAR : tok_raw[i], STAT_STORED);
        end
        tok_raw_len = 0;
        tok_norm_len = 0;
        tok_p = '0;
        passing = 0;
    endtask

    task automatic close_word();
        logic [1:0] st;
        flush(load_p, load_buf, load_len);
        if (load_raw == 0) st = STAT_EMPTY;
        else if (known_word(load_buf, load_len)) st = STAT_STORED;
        else if (word_count >= TABLE_DEPTH) st = STAT_FULL;
        else begin
            for (int k = 0; k < load_len; k++) words[word_count][k] = load_buf[k];
            word_len[word_count] = load_len;
            word_count++;
            st = STAT_STORED;
        end
        load_raw = 0;
        load_len = 0;
        load_p = '0;
        emit(KIND_STATUS, 16'h0, st);
    endtask

    task automatic predict(input logic [2:0] cmd, input logic [15:0] c);
        step_n = 0;
        case (cmd)
            CMD_CLEAR: begin
                word_count = 0;
                load_raw = 0;
                load_len = 0;
                load_p = '0;
            end
            CMD_DICT_CHAR: begin
                if (load_raw < MAX_WORD) begin
                    load_raw++;
                    normalize(load_p, load_buf, load_len, c ^ key);
                end
            end
            CMD_DICT_END: close_word();
            CMD_TEXT_CHAR: begin
                if (delimiter(c)) begin
                    close_token();
                    emit(KIND_TEXT, c, STAT_STORED);
                end else if (passing) begin
                    emit(KIND_TEXT, c, STAT_STORED);
                end else if (tok_raw_len < MAX_WORD) begin
                    tok_raw[tok_raw_len] = c;
                    tok_raw_len++;
                    normalize(tok_p, tok_norm, tok_norm_len, c);
                end else begin
                    // overlong token leaves unmasked
                    for (int i = 0; i < tok_raw_len; i++)
                        emit(KIND_TEXT, tok_raw[i], STAT_STORED);
                    emit(KIND_TEXT, c, STAT_STORED);
                    tok_raw_len = 0;
                    tok_norm_len = 0;
                    tok_p = '0;
                    passing = 1;
                end
            end
            CMD_LINE_END: close_token();
            default: ;
        endcase
        if (step_n > 0) expected_out[$].last = 1'b1;
    endtask

    // watch both channels at each rising edge
    always @(posedge aclk) begin
        masker_out_t got, want;
        if (!aresetn) begin
            key = '0;
            word_count = 0;
            load_raw = 0;
            load_len = 0;
            load_p = '0;
            tok_raw_len = 0;
            tok_norm_len = 0;
            tok_p = '0;
            passing = 0;
            fail_count = 0;
            result_count = 0;
            expected_out.delete();
        end else begin
            if (cfg_we) key = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got.kind = m_tuser;
                got.out_char = m_tdata[15:0];
                got.status = m_tdata[17:16];
                got.last = m_tlast;
                result_count++;
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected transfer kind=%0d char=%h status=%0d last=%0d",
                             $realtime, got.kind, got.out_char, got.status, got.last);
                    fail_count++;
                end else begin
                    want = expected_out.pop_front();
                    if (got !== want || m_tdata[23:18] !== 6'd0) begin
                        $display("%0t: mismatch expected kind=%0d char=%h status=%0d last=%0d",
                                 $realtime, want.kind, want.out_char, want.status, want.last);
                        $display("%0t:          actual   kind=%0d char=%h status=%0d last=%0d",
                                 $realtime, got.kind, got.out_char, got.status, got.last);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
        end
        pending_count = expected_out.size();
    end

endmodule

// ----- verif/tb_dictionary_word_masker.sv -----
// testbench top of the dictionary word masker: stimulus, key writes and verdict
// depends on dwm_pkg, dictionary_word_masker and dwm_checker
`timescale 1ns / 1ps

module tb_dictionary_word_masker;
    import dwm_pkg::*;

    localparam int MAX_WORD   = 32;
    localparam int CYCLE_CAP  = 900000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          fail_count, pending_count, result_count;
    int          cycle_count;
    int          sent_count;
    int          burst_left;
    logic [15:0] cur_key;
    logic [15:0] vocab[8][$];

    dictionary_word_masker #(.MAX_WORD(MAX_WORD), .TABLE_DEPTH(64)) dut (.*);

    dwm_checker #(.MAX_WORD(MAX_WORD), .TABLE_DEPTH(64)) checker_i (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // receiver stall pattern, with calm stretches
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (cycle_count % 3000 < 600) m_tready <= 1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one transfer, with bursts and gaps on the sender side
    task automatic send(input cmd_t cmd, input logic [15:0] c);
        if (burst_left == 0) begin
            s_tvalid = 0;
            repeat ($urandom_range(0, 4)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid = 1;
        s_tuser  <= cmd;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 0;
        burst_left--;
        sent_count++;
    endtask

    task automatic load_word(input logic [15:0] w[$]);
        foreach (w[i]) send(CMD_DICT_CHAR, w[i] ^ cur_key);
        send(CMD_DICT_END, 16'h0);
    endtask

    task automatic text_word(input logic [15:0] w[$]);
        foreach (w[i]) send(CMD_TEXT_CHAR, w[i]);
    endtask

    task automatic set_key(input logic [15:0] k);
        while (pending_count != 0) @(negedge aclk);
        repeat (3000) @(negedge aclk);
        cfg_we <= 1;
        cfg_wdata <= k;
        @(negedge aclk);
        cfg_we <= 0;
        cur_key = k;
    endtask

    function automatic logic [15:0] symbol_char();
        logic [15:0] s[9] = '{16'h40, 16'h24, 16'h2B, 16'h2D, 16'h5F, 16'h2A, 16'h27,
                              16'h22, 16'h70};
        return s[$urandom_range(0, 8)];
    endfunction

    function automatic logic [15:0] delim_char();
        logic [15:0] d[22] = '{16'h20, 16'h3B, 16'h2C, 16'h2E, 16'h21, 16'h3F, 16'h3A,
            16'h3D, 16'h5C, 16'h2F, 16'h3E, 16'h3C, 16'h60, 16'h7E, 16'h28, 16'h29,
            16'h26, 16'h5E, 16'h25, 16'h23, 16'h0A, 16'h09};
        return d[$urandom_range(0, 21)];
    endfunction

    function automatic logic [15:0] word_char();
        case ($urandom_range(0, 7))
            0: return 16'h0030 + 16'($urandom_range(0, 9));
            1: return symbol_char();
            2: return $urandom_range(0, 1) ? 16'h68 : 16'h48;
            3: return 16'($urandom());
            default: return 16'h0061 + 16'($urandom_range(0, 25));
        endcase
    endfunction

    initial begin
        logic [15:0] w[$];
        int          len, v;
        aresetn = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = CMD_CLEAR;
        cycle_count = 0;
        sent_count = 0;
        burst_left = 0;
        cur_key = 0;
        repeat (5) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: ph folding, leet, drops, empty word, duplicate, long words
        set_key(16'h0000);
        load_word('{16'h50, 16'h48, 16'h33, 16'h2D, 16'h41});  // "PH3-A"
        send(CMD_DICT_END, 16'h0);                             // empty word
        load_word('{16'h66, 16'h65, 16'h41});                  // duplicate "feA"
        load_word('{16'h2A, 16'h27});                          // normalizes to nothing
        load_word('{16'h70});                                  // lone p
        text_word('{16'h70, 16'h68, 16'h65, 16'h41});          // "pheA" masked
        send(CMD_TEXT_CHAR, 16'h20);
        text_word('{16'h22});                                  // empty normalized token
        send(CMD_LINE_END, 16'h0);
        send(CMD_LINE_END, 16'h0);                             // nothing pending
        send(CMD_TEXT_CHAR, 16'h2C);                           // bare delimiter
        send(cmd_t'(3'd7), 16'hFFFF);                          // unknown command
        send(cmd_t'(3'd5), 16'h0);
        text_word('{16'hFFFF, 16'h0000, 16'h70});
        send(CMD_LINE_END, 16'h0);
        set_key(16'hFFFF);
        w = {};
        repeat (MAX_WORD + 3) w.push_back(16'h0061);           // long word, cut
        load_word(w);
        text_word(w);                                          // long token passes
        send(CMD_TEXT_CHAR, 16'h0A);
        send(CMD_CLEAR, 16'h0);

        // random phases with different keys
        for (int phase = 0; phase < 4; phase++) begin
            set_key(phase == 3 ? 16'hFFFF : 16'($urandom()));
            for (int i = 0; i < 8; i++) begin
                w = {};
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                 : $urandom_range(1, 6);
                repeat (len) w.push_back(word_char());
                vocab[i] = w;
            end
            // table fill to full in one phase
            if (phase == 2) begin
                for (int i = 0; i < 66; i++) load_word('{16'h4000 + i[15:0]});
            end
            foreach (vocab[i]) load_word(vocab[i]);
            while (sent_count < 100 * (phase + 1) + 55) begin
                v = $urandom_range(0, 19);
                if (v < 12) text_word(vocab[$urandom_range(0, 7)]);
                else if (v < 16) begin
                    repeat ($urandom_range(1, 5)) send(CMD_TEXT_CHAR, word_char());
                end else if (v == 16) send(CMD_DICT_CHAR, 16'($urandom()));
                else if (v == 17 && $urandom_range(0, 5) == 0) send(CMD_CLEAR, 16'h0);
                else if (v == 18) send(cmd_t'($urandom_range(5, 7)), 16'($urandom()));
                if ($urandom_range(0, 4) == 0) send(CMD_LINE_END, 16'h0);
                else send(CMD_TEXT_CHAR, delim_char());
            end
            send(CMD_LINE_END, 16'h0);
        end

        while (pending_count != 0) @(negedge aclk);
        repeat (3000) @(negedge aclk);
        $display("sent %0d input transfers, checked %0d output transfers", sent_count,
                 result_count);
        $display("covered leet and ph folding, duplicates, full table, long tokens, 4 keys");
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/dwm_pkg.sv
sv/dwm_buf.sv
sv/dwm_dict.sv
sv/dictionary_word_masker.sv
verif/dwm_checker.sv
verif/tb_dictionary_word_masker.sv
